FILE: rtl/cfc_pkg.sv
// Package for the checksum frame checker: constants, codes, state and
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package cfc_pkg;

   // default frame limit in bytes
   localparam int FRAME_LIMIT_DEF = 256;

   // adler-32 modulus
   localparam logic [16:0] ADLER_MOD = 17'd65521;

   // shortest frame: star plus eight hex digits
   localparam int MIN_FRAME = 9;

   // character codes
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_L     = 8'h4C;
   localparam logic [7:0] CHAR_M     = 8'h4D;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_D     = 8'h44;

   // result error codes
   typedef enum logic [2:0] {
      ERR_OK,
      ERR_SHORT,
      ERR_LONG,
      ERR_NO_STAR,
      ERR_BAD_HEX,
      ERR_MISMATCH
   } err_type;

   // frame classes
   typedef enum logic [1:0] {
      FT_UNKNOWN,
      FT_TLM,
      FT_EVT,
      FT_CMD
   } frame_class_type;

   // controller states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CHECK,
      ST_STAR_ADDR,
      ST_SCAN,
      ST_WALK_ADDR,
      ST_WALK,
      ST_COMPARE,
      ST_FINISH
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic    load_en;
      logic    line_clear;
      logic    ptr_load_star;
      logic    ptr_inc;
      logic    ptr_clear;
      logic    hex_shift;
      logic    walk_step;
      logic    err_load;
      err_type err_code;
      logic    rsp_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic beyond;
      logic too_short;
      logic star_ok;
      logic hex_ok;
      logic star_zero;
      logic walk_last;
      logic sum_match;
      logic rsp_free;
   } status_type;

   // line terminator test
   function automatic logic is_eol(input logic [7:0] b);
      return (b == CHAR_CR) || (b == CHAR_LF);
   endfunction

   // classify a frame from its first three bytes
   function automatic frame_class_type class_of(input logic [7:0] b0,
                                                input logic [7:0] b1,
                                                input logic [7:0] b2);
      frame_class_type c;
      c = FT_UNKNOWN;
      if (b0 == CHAR_T && b1 == CHAR_L && b2 == CHAR_M) begin
         c = FT_TLM;
      end else if (b0 == CHAR_E && b1 == CHAR_V && b2 == CHAR_T) begin
         c = FT_EVT;
      end else if (b0 == CHAR_C && b1 == CHAR_M && b2 == CHAR_D) begin
         c = FT_CMD;
      end
      return c;
   endfunction

endpackage

FILE: rtl/checksum_frame_checker_top.sv
// The time from the line's final byte to the result grows with the bytes before
// the star, which the walk reads one at a time over the store read port; lines
// rejected before the walk finish without it.
// Throughput: one byte per cycle while a line loads, then no byte is taken
// until the line's result sits in the output register.
// Reset: synchronous, active high; clears line state, controller and result.
`timescale 1ns / 1ps

module checksum_frame_checker_top
   import cfc_pkg::*;
#(
   parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_line_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_accepted,
   output logic [2:0] rsp_error_code,
   output logic [1:0] rsp_frame_type,
   output logic [7:0] rsp_payload_length
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   cfc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // store, sums and result register
   cfc_datapath #(
      .FRAME_LIMIT (FRAME_LIMIT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_line_byte      (req_line_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_error_code     (rsp_error_code),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

FILE: rtl/cfc_ctrl.sv
// Controller state machine of the checksum frame checker.
// Depends on cfc_pkg; drives commands to cfc_datapath and reads its status.
`timescale 1ns / 1ps

module cfc_ctrl
   import cfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_byte,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic [3:0]     cnt_ff, cnt_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.err_code = ERR_OK;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall   = 1'b0;
            cmd.load_en = 1'b1;
            if (req_valid && req_last_byte) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.beyond) begin
               cmd.err_load = 1'b1;
               cmd.err_code = ERR_LONG;
               state_in     = ST_FINISH;
            end else if (status.too_short) begin
               cmd.err_load = 1'b1;
               cmd.err_code = ERR_SHORT;
               state_in     = ST_FINISH;
            end else begin
               cmd.ptr_load_star = 1'b1;
               state_in          = ST_STAR_ADDR;
            end
         end
         ST_STAR_ADDR: begin
            cmd.ptr_inc = 1'b1;
            cnt_in      = '0;
            state_in    = ST_SCAN;
         end
         // star then eight hex digits, one per cycle
         ST_SCAN: begin
            if (cnt_ff == 4'd0) begin
               if (!status.star_ok) begin
                  cmd.err_load = 1'b1;
                  cmd.err_code = ERR_NO_STAR;
                  state_in     = ST_FINISH;
               end else begin
                  cmd.ptr_inc = 1'b1;
                  cnt_in      = cnt_ff + 4'd1;
               end
            end else if (!status.hex_ok) begin
               cmd.err_load = 1'b1;
               cmd.err_code = ERR_BAD_HEX;
               state_in     = ST_FINISH;
            end else begin
               cmd.hex_shift = 1'b1;
               if (cnt_ff == 4'd8) begin
                  cmd.ptr_clear = 1'b1;
                  state_in      = ST_WALK_ADDR;
               end else begin
                  cmd.ptr_inc = 1'b1;
                  cnt_in      = cnt_ff + 4'd1;
               end
            end
         end
         ST_WALK_ADDR: begin
            if (status.star_zero) begin
               state_in = ST_COMPARE;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = ST_WALK;
            end
         end
         // checksum walk, one stored byte per cycle
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            cmd.ptr_inc   = 1'b1;
            if (status.walk_last) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.err_load = 1'b1;
            cmd.err_code = status.sum_match ? ERR_OK : ERR_MISMATCH;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.line_clear = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // scan counter stays within the star and eight digits
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'd8)
      else $error("scan counter out of range");

   // a line end always leads into the check
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && req_valid && req_last_byte) |=> state_ff == ST_CHECK)
      else $error("line end not followed by check");

   // input is held off during the walk, as in every state outside loading
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> req_stall)
      else $error("input open during walk");

endmodule

FILE: rtl/cfc_datapath.sv
// Datapath of the checksum frame checker: line store, length tracking,
// hex capture, adler-32 sums and result register. Depends on cfc_pkg.
`timescale 1ns / 1ps

module cfc_datapath
   import cfc_pkg::*;
#(
   parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_line_byte,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_accepted,
   output logic [2:0] rsp_error_code,
   output logic [1:0] rsp_frame_type,
   output logic [7:0] rsp_payload_length
);

   localparam int AW = (FRAME_LIMIT > 1) ? $clog2(FRAME_LIMIT) : 1;
   localparam int CW = $clog2(FRAME_LIMIT + 1);
   localparam logic [CW-1:0] LIMIT_C = CW'(FRAME_LIMIT);
   localparam logic [CW-1:0] MIN_C   = CW'(MIN_FRAME);

   logic [7:0]    line_store [FRAME_LIMIT];
   logic [7:0]    rd_data_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] len_ff, len_in;
   logic          beyond_ff, beyond_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [15:0]   sum_low_ff, sum_low_in;
   logic [15:0]   sum_high_ff, sum_high_in;
   logic [31:0]   recv_ff;
   logic [7:0]    head_ff [4];
   err_type       err_ff;
   logic          rsp_valid_ff;
   logic          rsp_accepted_ff;
   logic [2:0]    rsp_error_code_ff;
   logic [1:0]    rsp_frame_type_ff;
   logic [7:0]    rsp_payload_length_ff;

   logic          take;
   logic          store_en;
   logic [CW-1:0] star;
   logic          hex_ok;
   logic [3:0]    hex_val;
   logic [16:0]   low_sum, high_sum;
   logic [15:0]   low_next, high_next;
   logic          ok;
   frame_class_type cls;

   assign take     = cmd.load_en && req_valid;
   assign store_en = take && (count_ff < LIMIT_C);
   assign star     = len_ff - MIN_C;

   // line store, one write and one registered read
   always_ff @(posedge clock) begin
      if (store_en) begin
         line_store[count_ff[AW-1:0]] <= req_line_byte;
      end
      rd_data_ff <= line_store[ptr_ff[AW-1:0]];
   end

   // hex digit decode of the read byte
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = '0;
      if (rd_data_ff >= 8'h30 && rd_data_ff <= 8'h39) begin
         hex_val = 4'(rd_data_ff - 8'h30);
      end else if (rd_data_ff >= 8'h41 && rd_data_ff <= 8'h46) begin
         hex_val = 4'(rd_data_ff - 8'h37);
      end else if (rd_data_ff >= 8'h61 && rd_data_ff <= 8'h66) begin
         hex_val = 4'(rd_data_ff - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // adler-32 step, each sum kept below the modulus
   always_comb begin
      low_sum  = {1'b0, sum_low_ff} + {9'd0, rd_data_ff};
      low_next = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
      high_sum = {1'b0, sum_high_ff} + {1'b0, low_next};
      high_next = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD)
                                          : high_sum[15:0];
   end

   // line tracking: count, trimmed length, overflow flag
   always_comb begin
      count_in  = count_ff;
      len_in    = len_ff;
      beyond_in = beyond_ff;
      if (cmd.line_clear) begin
         count_in  = '0;
         len_in    = '0;
         beyond_in = 1'b0;
      end else if (store_en) begin
         count_in = count_ff + CW'(1);
         if (!is_eol(req_line_byte)) begin
            len_in = count_ff + CW'(1);
         end
      end else if (take && !is_eol(req_line_byte)) begin
         beyond_in = 1'b1;
      end
   end

   // read pointer, walk index and sums
   always_comb begin
      ptr_in      = ptr_ff;
      walk_in     = walk_ff;
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      if (cmd.line_clear || cmd.ptr_clear) begin
         ptr_in      = '0;
         walk_in     = '0;
         sum_low_in  = 16'd1;
         sum_high_in = '0;
      end else begin
         if (cmd.ptr_load_star) begin
            ptr_in = star;
         end else if (cmd.ptr_inc) begin
            ptr_in = ptr_ff + CW'(1);
         end
         if (cmd.walk_step) begin
            walk_in     = walk_ff + CW'(1);
            sum_low_in  = low_next;
            sum_high_in = high_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         len_ff      <= '0;
         beyond_ff   <= 1'b0;
         ptr_ff      <= '0;
         walk_ff     <= '0;
         sum_low_ff  <= 16'd1;
         sum_high_ff <= '0;
      end else begin
         count_ff    <= count_in;
         len_ff      <= len_in;
         beyond_ff   <= beyond_in;
         ptr_ff      <= ptr_in;
         walk_ff     <= walk_in;
         sum_low_ff  <= sum_low_in;
         sum_high_ff <= sum_high_in;
      end
   end

   // received checksum, head bytes and error code
   always_ff @(posedge clock) begin
      if (cmd.hex_shift) begin
         recv_ff <= {recv_ff[27:0], hex_val};
      end
      if (cmd.walk_step && walk_ff < CW'(4)) begin
         head_ff[walk_ff[1:0]] <= rd_data_ff;
      end
      if (reset) begin
         err_ff <= ERR_OK;
      end else if (cmd.err_load) begin
         err_ff <= cmd.err_code;
      end
   end

   // status to the controller
   always_comb begin
      status.beyond    = beyond_ff;
      status.too_short = len_ff < MIN_C;
      status.star_ok   = rd_data_ff == CHAR_STAR;
      status.hex_ok    = hex_ok;
      status.star_zero = star == '0;
      status.walk_last = walk_ff == (star - CW'(1));
      status.sum_match = {sum_high_ff, sum_low_ff} == recv_ff;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // result fields
   always_comb begin
      ok  = err_ff == ERR_OK;
      cls = FT_UNKNOWN;
      if (star >= CW'(4) && head_ff[3] == CHAR_COMMA) begin
         cls = class_of(head_ff[0], head_ff[1], head_ff[2]);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_accepted_ff       <= ok;
         rsp_error_code_ff     <= err_ff;
         rsp_frame_type_ff     <= ok ? cls : FT_UNKNOWN;
         rsp_payload_length_ff <= ok ? 8'(star) : 8'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_error_code     = rsp_error_code_ff;
   assign rsp_frame_type     = rsp_frame_type_ff;
   assign rsp_payload_length = rsp_payload_length_ff;

   // trimmed length never passes the stored count, nor the count the limit
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= count_ff && count_ff <= LIMIT_C)
      else $error("line length out of range");

   // a new result only loads into a free slot
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten");

   // rejected frames carry no class, no length and an error code other than ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_accepted_ff) |->
         (rsp_frame_type_ff == FT_UNKNOWN && rsp_payload_length_ff == 8'd0
          && rsp_error_code_ff != ERR_OK))
      else $error("rejected result inconsistent");

   // walk stays before the star
   assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> walk_ff < star)
      else $error("walk past star");

endmodule
